[src/spi_mte_pkg.sv]
// ----------------------------------------------------------------------------
// spi_mte_pkg
// Shared types, sizes and codes for the SPI master transaction engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spi_mte_pkg;

  // Store sizes
  localparam int RX_DEPTH = 1 << 7;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_FW    = $clog2(RX_DEPTH + 1);
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_START   = 3'd1,
    KIND_TX_SLOT = 3'd2,
    KIND_RX_BYTE = 3'd3,
    KIND_POP     = 3'd4,
    KIND_FLUSH   = 3'd5,
    KIND_REQUEST = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_DROPPED = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the item and start the store reads
    logic commit;   // update state and load the result register
  } ctrl_cmd_t;

endpackage : spi_mte_pkg

`default_nettype wire

[src/spi_mte_in_if.sv]
// ----------------------------------------------------------------------------
// spi_mte_in_if
// Command channel: one beat carries one engine command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spi_mte_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] index;
  logic [7:0] data_byte;
  logic [7:0] receive_length;
  logic [7:0] transmit_length;

  modport source (output valid, kind, index, data_byte, receive_length,
                  transmit_length, input ready);
  modport sink   (input valid, kind, index, data_byte, receive_length,
                  transmit_length, output ready);
endinterface : spi_mte_in_if

`default_nettype wire

[src/spi_mte_out_if.sv]
// ----------------------------------------------------------------------------
// spi_mte_out_if
// Result channel: one beat carries one command result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spi_mte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       transfer_done;
  logic       buffer_busy;
  logic [7:0] overflow_count;

  modport source (output valid, out_byte, byte_valid, status, transfer_done,
                  buffer_busy, overflow_count, input ready);
  modport sink   (input valid, out_byte, byte_valid, status, transfer_done,
                  buffer_busy, overflow_count, output ready);
endinterface : spi_mte_out_if

`default_nettype wire

[src/spi_mte_ctrl.sv]
// ----------------------------------------------------------------------------
// spi_mte_ctrl
// Two-state sequencer: take a beat, then commit it once the result register
// is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spi_mte_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  output spi_mte_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_free;

  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the previous result has gone
        if (res_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> st_r == ST_EXEC)
    else $error("capture did not move to execute");

  a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC && out_valid_r && !out_ready) |=> st_r == ST_EXEC)
    else $error("commit overran a pending result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result beat dropped before it was taken");

endmodule : spi_mte_ctrl

`default_nettype wire

[src/spi_mte_dp.sv]
// ----------------------------------------------------------------------------
// spi_mte_dp
// Datapath: transmit and receive stores, transaction counters, ring
// pointers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spi_mte_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire spi_mte_pkg::ctrl_cmd_t cmd,
  input  wire  [2:0]              in_kind,
  input  wire  [7:0]              in_index,
  input  wire  [7:0]              in_data_byte,
  input  wire  [7:0]              in_receive_length,
  input  wire  [7:0]              in_transmit_length,
  output logic [7:0]              out_byte,
  output logic                    out_byte_valid,
  output logic [1:0]              out_status,
  output logic                    out_transfer_done,
  output logic                    out_buffer_busy,
  output logic [7:0]              out_overflow_count
);

  localparam int RX_AW = spi_mte_pkg::RX_AW;
  localparam int RX_FW = spi_mte_pkg::RX_FW;
  localparam int TX_AW = spi_mte_pkg::TX_AW;
  localparam logic [8:0]       TX_LIMIT = 9'(spi_mte_pkg::TX_DEPTH);
  localparam logic [RX_FW-1:0] RX_FULL  = RX_FW'(spi_mte_pkg::RX_DEPTH);
  localparam logic [RX_AW-1:0] RX_LAST  = RX_AW'(spi_mte_pkg::RX_DEPTH - 1);
  localparam logic [RX_AW-1:0] PTR_STEP = RX_AW'(1);
  localparam logic [RX_FW-1:0] FILL_STEP = RX_FW'(1);

  // Stores
  logic [7:0] tx_mem [spi_mte_pkg::TX_DEPTH];
  logic [7:0] rx_mem [spi_mte_pkg::RX_DEPTH];

  // Captured beat (payload, no reset)
  spi_mte_pkg::kind_t kind_r;
  logic [7:0] index_r, data_r, rlen_r, tlen_r;
  logic [7:0] tx_rd_r, rx_rd_r;

  // Engine state
  logic [RX_AW-1:0] rx_wr_ptr_r, rx_wr_ptr_nxt;
  logic [RX_AW-1:0] rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [RX_FW-1:0] rx_fill_r, rx_fill_nxt;
  logic [7:0] tx_pos_r, tx_pos_nxt;
  logic [7:0] tx_left_r, tx_left_nxt;
  logic [7:0] rx_left_r, rx_left_nxt;
  logic [7:0] slots_r, slots_nxt;
  logic [7:0] refused_r, refused_nxt;

  // Result register
  logic [7:0]            obyte_r, obyte_nxt;
  logic                  bvalid_r, bvalid_nxt;
  spi_mte_pkg::status_t  status_r, status_nxt;

  logic tx_we, rx_we;

  // Capture the beat and read both stores at the current pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= spi_mte_pkg::kind_t'(in_kind);
      index_r <= in_index;
      data_r  <= in_data_byte;
      rlen_r  <= in_receive_length;
      tlen_r  <= in_transmit_length;
      tx_rd_r <= tx_mem[tx_pos_r[TX_AW-1:0]];
      rx_rd_r <= rx_mem[rx_rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[index_r[TX_AW-1:0]] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wr_ptr_r] <= data_r;
    end
  end

  always_comb begin
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    rx_fill_nxt   = rx_fill_r;
    tx_pos_nxt    = tx_pos_r;
    tx_left_nxt   = tx_left_r;
    rx_left_nxt   = rx_left_r;
    slots_nxt     = slots_r;
    refused_nxt   = refused_r;
    obyte_nxt     = 8'h00;
    bvalid_nxt    = 1'b0;
    status_nxt    = spi_mte_pkg::STAT_OK;
    tx_we         = 1'b0;
    rx_we         = 1'b0;
    if (cmd.commit) begin
      case (kind_r)
        spi_mte_pkg::KIND_LOAD: begin
          tx_we = ({1'b0, index_r} < TX_LIMIT);
        end
        spi_mte_pkg::KIND_START: begin
          // an empty start leaves the transaction alone
          if (rlen_r != 8'd0 || tlen_r != 8'd0) begin
            tx_pos_nxt  = 8'd0;
            tx_left_nxt = tlen_r;
            rx_left_nxt = rlen_r;
            slots_nxt   = (rlen_r > tlen_r) ? rlen_r : tlen_r;
          end
        end
        spi_mte_pkg::KIND_TX_SLOT: begin
          if (slots_r == 8'd0) begin
            status_nxt = spi_mte_pkg::STAT_EMPTY;
          end else begin
            slots_nxt  = slots_r - 8'd1;
            bvalid_nxt = 1'b1;
            if (tx_left_r == 8'd0) begin
              obyte_nxt = spi_mte_pkg::IDLE_BYTE;
            end else begin
              obyte_nxt   = ({1'b0, tx_pos_r} < TX_LIMIT) ? tx_rd_r
                                                          : spi_mte_pkg::IDLE_BYTE;
              tx_pos_nxt  = tx_pos_r + 8'd1;
              tx_left_nxt = tx_left_r - 8'd1;
            end
          end
        end
        spi_mte_pkg::KIND_RX_BYTE: begin
          if (rx_left_r != 8'd0) begin
            rx_left_nxt = rx_left_r - 8'd1;
            if (rx_fill_r >= RX_FULL) begin
              status_nxt = spi_mte_pkg::STAT_DROPPED;
            end else begin
              rx_we         = 1'b1;
              rx_wr_ptr_nxt = (rx_wr_ptr_r == RX_LAST) ? '0 : rx_wr_ptr_r + PTR_STEP;
              rx_fill_nxt   = rx_fill_r + FILL_STEP;
            end
          end
        end
        spi_mte_pkg::KIND_POP: begin
          if (rx_fill_r == '0) begin
            status_nxt = spi_mte_pkg::STAT_EMPTY;
          end else begin
            obyte_nxt     = rx_rd_r;
            bvalid_nxt    = 1'b1;
            rx_rd_ptr_nxt = (rx_rd_ptr_r == RX_LAST) ? '0 : rx_rd_ptr_r + PTR_STEP;
            rx_fill_nxt   = rx_fill_r - FILL_STEP;
          end
        end
        spi_mte_pkg::KIND_FLUSH: begin
          rx_rd_ptr_nxt = rx_wr_ptr_r;
          rx_fill_nxt   = '0;
        end
        spi_mte_pkg::KIND_REQUEST: begin
          if (tx_left_r != 8'd0) begin
            refused_nxt = refused_r + 8'd1;
            status_nxt  = spi_mte_pkg::STAT_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      rx_fill_r   <= '0;
      tx_pos_r    <= 8'd0;
      tx_left_r   <= 8'd0;
      rx_left_r   <= 8'd0;
      slots_r     <= 8'd0;
      refused_r   <= 8'd0;
    end else begin
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_pos_r    <= tx_pos_nxt;
      tx_left_r   <= tx_left_nxt;
      rx_left_r   <= rx_left_nxt;
      slots_r     <= slots_nxt;
      refused_r   <= refused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      obyte_r  <= obyte_nxt;
      bvalid_r <= bvalid_nxt;
      status_r <= status_nxt;
    end
  end

  // Flags come from the counters, which only move at commit
  assign out_byte           = obyte_r;
  assign out_byte_valid     = bvalid_r;
  assign out_status         = status_r;
  assign out_transfer_done  = (slots_r == 8'd0);
  assign out_buffer_busy    = (tx_left_r != 8'd0);
  assign out_overflow_count = refused_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill_r <= RX_FULL)
    else $error("receive fill beyond depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r == '0 || rx_fill_r == RX_FULL) |-> rx_wr_ptr_r == rx_rd_ptr_r)
    else $error("ring pointers disagree with fill");

  a_tx_within_slots: assert property (@(posedge clk) disable iff (!rst_n)
    tx_left_r <= slots_r)
    else $error("transmit bytes exceed remaining slots");

endmodule : spi_mte_dp

`default_nettype wire

[src/spi_master_transaction_engine_core.sv]
// ----------------------------------------------------------------------------
// spi_master_transaction_engine_core
// SPI master transaction engine: transmit store, transaction counters and a
// receive ring FIFO, driven one command beat at a time.
// ----------------------------------------------------------------------------
//
//   Channel  | Dir | Beat contents
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | kind, index, data_byte, receive_length, transmit_length
//   out_ch   | out | out_byte, byte_valid, status, transfer_done,
//            |     | buffer_busy, overflow_count
//
// Each command is captured, which latches the beat and reads both stores
// (the store read ports are registered), and then committed, which updates
// the counters and loads the result register. Synchronous active-low reset
// clears counters, pointers and handshake state; the stores are left as they
// are. A new command beat is taken while a result still waits; the commit
// then holds until out_ch has taken the earlier result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spi_master_transaction_engine_core (
  input  wire           clk,
  input  wire           rst_n,
  spi_mte_in_if.sink    in_ch,
  spi_mte_out_if.source out_ch
);

  spi_mte_pkg::ctrl_cmd_t cmd;

  // Sequencer: owns the handshakes and says when to capture and commit
  spi_mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: stores, counters and the result register
  spi_mte_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_kind            (in_ch.kind),
    .in_index           (in_ch.index),
    .in_data_byte       (in_ch.data_byte),
    .in_receive_length  (in_ch.receive_length),
    .in_transmit_length (in_ch.transmit_length),
    .out_byte           (out_ch.out_byte),
    .out_byte_valid     (out_ch.byte_valid),
    .out_status         (out_ch.status),
    .out_transfer_done  (out_ch.transfer_done),
    .out_buffer_busy    (out_ch.buffer_busy),
    .out_overflow_count (out_ch.overflow_count)
  );

endmodule : spi_master_transaction_engine_core

`default_nettype wire

[tb/spi_master_transaction_engine_core_test.sv]
// ----------------------------------------------------------------------------
// spi_master_transaction_engine_core_test
// Self-checking bench for the SPI master transaction engine. A queue of
// commands (a directed opening, then random transactions, request storms,
// FIFO drains and noise) is fed beat by beat in bursts with gaps; every
// accepted command is run through a cycle-free model of the engine, and each
// result beat is compared field by field with the oldest predicted result,
// while the result side stalls on a rolling pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_master_transaction_engine_core_test;

  // Unused command code: the engine must answer it and change nothing
  localparam logic [2:0] KIND_SPARE = 3'd7;

  localparam int COMMAND_TARGET = 1850;  // stop queueing random work here
  localparam int STALL_LIMIT    = 5000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES  = 20;    // quiet tail to catch stray results
  localparam int REPORT_CAP     = 100;   // mute mismatch reports beyond this

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] index;
    logic [7:0] data_byte;
    logic [7:0] rx_len;
    logic [7:0] tx_len;
  } spi_cmd_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    spi_mte_pkg::status_t status;
    logic                 transfer_done;
    logic                 buffer_busy;
    logic [7:0]           overflow_count;
  } spi_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  spi_mte_in_if  cmd_if ();
  spi_mte_out_if res_if ();

  spi_master_transaction_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (res_if)
  );

  // --------------------------------------------------------------------------
  // Engine model: transmit store, transaction counters and receive ring.
  // Counters start at zero; the stores are only ever read where written.
  // --------------------------------------------------------------------------
  logic [7:0]                    tx_image [spi_mte_pkg::TX_DEPTH];
  logic [7:0]                    rx_image [spi_mte_pkg::RX_DEPTH];
  logic [spi_mte_pkg::RX_AW-1:0] rx_head    = '0;  // next ring entry to write
  logic [spi_mte_pkg::RX_AW-1:0] rx_tail    = '0;  // next ring entry to pop
  logic [spi_mte_pkg::RX_FW-1:0] rx_level   = '0;
  logic [7:0]                    tx_cursor  = '0;
  logic [7:0]                    tx_owed    = '0;
  logic [7:0]                    rx_owed    = '0;
  logic [7:0]                    slots_owed = '0;
  logic [7:0]                    refusals   = '0;

  int unsigned drops_seen    = 0;
  int unsigned refusals_seen = 0;
  int unsigned pops_seen     = 0;

  function automatic logic [spi_mte_pkg::RX_AW-1:0] ring_next(
      logic [spi_mte_pkg::RX_AW-1:0] p);
    return (int'(p) == spi_mte_pkg::RX_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // Apply one command to the model and return the result it must produce
  function automatic spi_result_t advance_engine(spi_cmd_t cmd);
    spi_result_t res;
    res        = '0;
    res.status = spi_mte_pkg::STAT_OK;
    case (cmd.kind)
      spi_mte_pkg::KIND_LOAD: begin
        if (int'(cmd.index) < spi_mte_pkg::TX_DEPTH) tx_image[cmd.index] = cmd.data_byte;
      end
      spi_mte_pkg::KIND_START: begin
        // A start with both lengths zero leaves the transaction alone;
        // any other start replaces every count, even mid-transaction
        if (cmd.rx_len != 8'd0 || cmd.tx_len != 8'd0) begin
          tx_cursor  = '0;
          tx_owed    = cmd.tx_len;
          rx_owed    = cmd.rx_len;
          slots_owed = (cmd.rx_len > cmd.tx_len) ? cmd.rx_len : cmd.tx_len;
        end
      end
      spi_mte_pkg::KIND_TX_SLOT: begin
        if (slots_owed == 8'd0) begin
          res.status = spi_mte_pkg::STAT_EMPTY;
        end else begin
          slots_owed     = slots_owed - 8'd1;
          res.byte_valid = 1'b1;
          if (tx_owed == 8'd0) begin
            // transmit count used up: pad with the idle byte
            res.out_byte = spi_mte_pkg::IDLE_BYTE;
          end else begin
            res.out_byte = (int'(tx_cursor) < spi_mte_pkg::TX_DEPTH)
                           ? tx_image[tx_cursor] : spi_mte_pkg::IDLE_BYTE;
            tx_cursor    = tx_cursor + 8'd1;
            tx_owed      = tx_owed - 8'd1;
          end
        end
      end
      spi_mte_pkg::KIND_RX_BYTE: begin
        // Bytes past the receive length vanish with an ok status
        if (rx_owed != 8'd0) begin
          rx_owed = rx_owed - 8'd1;
          if (int'(rx_level) >= spi_mte_pkg::RX_DEPTH) begin
            res.status = spi_mte_pkg::STAT_DROPPED;
            drops_seen++;
          end else begin
            rx_image[rx_head] = cmd.data_byte;
            rx_head           = ring_next(rx_head);
            rx_level          = rx_level + 1'b1;
          end
        end
      end
      spi_mte_pkg::KIND_POP: begin
        if (rx_level == '0) begin
          res.status = spi_mte_pkg::STAT_EMPTY;
        end else begin
          res.out_byte   = rx_image[rx_tail];
          res.byte_valid = 1'b1;
          rx_tail        = ring_next(rx_tail);
          rx_level       = rx_level - 1'b1;
          pops_seen++;
        end
      end
      spi_mte_pkg::KIND_FLUSH: begin
        rx_tail  = rx_head;
        rx_level = '0;
      end
      spi_mte_pkg::KIND_REQUEST: begin
        if (tx_owed != 8'd0) begin
          refusals   = refusals + 8'd1;
          res.status = spi_mte_pkg::STAT_EMPTY;
          refusals_seen++;
        end
      end
      default: ;
    endcase
    res.transfer_done  = (slots_owed == 8'd0);
    res.buffer_busy    = (tx_owed != 8'd0);
    res.overflow_count = refusals;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Command planning. Track which transmit entries have been loaded so that
  // no transaction ever sends an entry that was never written.
  // --------------------------------------------------------------------------
  spi_cmd_t    command_queue [$];
  bit          tx_loaded [spi_mte_pkg::TX_DEPTH];
  int unsigned planned_count = 0;

  function automatic void queue_command(logic [2:0] kind, logic [7:0] index,
                                        logic [7:0] data, logic [7:0] rx_len,
                                        logic [7:0] tx_len);
    spi_cmd_t cmd;
    cmd.kind      = kind;
    cmd.index     = index;
    cmd.data_byte = data;
    cmd.rx_len    = rx_len;
    cmd.tx_len    = tx_len;
    if (kind == spi_mte_pkg::KIND_LOAD) tx_loaded[index] = 1'b1;
    command_queue.push_back(cmd);
    // ignored commands do not count towards the random budget
    if (kind != KIND_SPARE &&
        !(kind == spi_mte_pkg::KIND_START && rx_len == 8'd0 && tx_len == 8'd0))
      planned_count++;
  endfunction

  // Any command with every field random; the engine looks only at its own
  function automatic void queue_op(logic [2:0] kind);
    queue_command(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Load any missing entries the transaction will send, then start it
  function automatic void queue_start(logic [7:0] rx_len, logic [7:0] tx_len);
    for (int i = 0; i < int'(tx_len); i++)
      if (!tx_loaded[i])
        queue_command(spi_mte_pkg::KIND_LOAD, 8'(i), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    queue_command(spi_mte_pkg::KIND_START, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), rx_len, tx_len);
  endfunction

  // Mostly short transactions, now and then one of any length
  function automatic logic [7:0] pick_length();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 12));
  endfunction

  function automatic void queue_opening();
    // idle engine: empty pop, slot with no transaction, granted request
    queue_op(spi_mte_pkg::KIND_POP);
    queue_op(spi_mte_pkg::KIND_TX_SLOT);
    queue_op(spi_mte_pkg::KIND_REQUEST);
    queue_op(spi_mte_pkg::KIND_FLUSH);
    queue_command(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_command(spi_mte_pkg::KIND_START, 8'h00, 8'h00, 8'h00, 8'h00);
    // store extremes, including the last entry
    queue_command(spi_mte_pkg::KIND_LOAD, 8'd0, 8'hFF, 8'h00, 8'h00);
    queue_command(spi_mte_pkg::KIND_LOAD, 8'd1, 8'h00, 8'hFF, 8'hFF);
    queue_command(spi_mte_pkg::KIND_LOAD, 8'd255, 8'hA5, 8'h00, 8'h00);
    queue_command(spi_mte_pkg::KIND_LOAD, 8'd2, 8'h5A, 8'h00, 8'h00);
    // keep one byte, send three; a request now is refused
    queue_command(spi_mte_pkg::KIND_START, 8'h00, 8'h00, 8'd1, 8'd3);
    queue_op(spi_mte_pkg::KIND_REQUEST);
    queue_op(spi_mte_pkg::KIND_TX_SLOT);
    queue_command(spi_mte_pkg::KIND_RX_BYTE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_op(spi_mte_pkg::KIND_TX_SLOT);
    // past receive length
    queue_command(spi_mte_pkg::KIND_RX_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // restart mid-transaction: receive only, longest length
    queue_command(spi_mte_pkg::KIND_START, 8'hFF, 8'hFF, 8'd255, 8'd0);
    queue_op(spi_mte_pkg::KIND_TX_SLOT);
    queue_command(spi_mte_pkg::KIND_RX_BYTE, 8'h00, 8'h3C, 8'h00, 8'h00);
    queue_op(spi_mte_pkg::KIND_POP);
    queue_op(spi_mte_pkg::KIND_POP);
    queue_op(spi_mte_pkg::KIND_POP);
    queue_command(spi_mte_pkg::KIND_RX_BYTE, 8'h00, 8'h11, 8'h00, 8'h00);
    queue_op(spi_mte_pkg::KIND_FLUSH);
    queue_op(spi_mte_pkg::KIND_POP);
  endfunction

  // Well-formed transaction: a slot per byte with the received byte beside
  // it, a few pops and requests mixed in, and now and then a restart
  function automatic void queue_transaction();
    logic [7:0] rx_len;
    logic [7:0] tx_len;
    int         slots;
    rx_len = pick_length();
    tx_len = pick_length();
    queue_start(rx_len, tx_len);
    slots = int'((rx_len > tx_len) ? rx_len : tx_len) + $urandom_range(0, 2);
    for (int i = 0; i < slots; i++) begin
      queue_op(spi_mte_pkg::KIND_TX_SLOT);
      if ($urandom_range(0, 7) != 0)  queue_op(spi_mte_pkg::KIND_RX_BYTE);
      if ($urandom_range(0, 9) == 0)  queue_op(spi_mte_pkg::KIND_POP);
      if ($urandom_range(0, 15) == 0) queue_op(spi_mte_pkg::KIND_REQUEST);
      if ($urandom_range(0, 59) == 0) queue_start(pick_length(), pick_length());
    end
    repeat ($urandom_range(0, 6)) queue_op(spi_mte_pkg::KIND_POP);
    if ($urandom_range(0, 9) == 0) queue_op(spi_mte_pkg::KIND_FLUSH);
  endfunction

  // Hold the buffer busy and hammer it with requests
  function automatic void queue_request_storm(int requests);
    queue_start(8'($urandom_range(0, 4)), 8'($urandom_range(1, 20)));
    repeat (requests) queue_op(spi_mte_pkg::KIND_REQUEST);
    repeat ($urandom_range(0, 25)) queue_op(spi_mte_pkg::KIND_TX_SLOT);
  endfunction

  function automatic void queue_drain();
    repeat ($urandom_range(5, 60)) queue_op(spi_mte_pkg::KIND_POP);
    if ($urandom_range(0, 2) == 0) queue_op(spi_mte_pkg::KIND_FLUSH);
  endfunction

  // Broken traffic: any command in any order
  function automatic void queue_noise();
    logic [2:0] kind;
    repeat ($urandom_range(3, 12)) begin
      kind = 3'($urandom_range(0, 7));
      if (kind == spi_mte_pkg::KIND_START)
        queue_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        queue_op(kind);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: offer queued commands in bursts separated by gaps.
  // Predict each command's result on the edge its beat is taken.
  // --------------------------------------------------------------------------
  spi_result_t engine_results_due [$];
  spi_cmd_t    cmd_on_bus        = '0;
  bit          offering          = 1'b0;
  int unsigned burst_left        = 0;
  int unsigned gap_left          = 0;
  int unsigned commands_accepted = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      offering   = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (offering && cmd_if.ready) begin
        engine_results_due.push_back(advance_engine(cmd_on_bus));
        commands_accepted++;
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (!offering && command_queue.size() != 0) begin
        // burst used up: pick the next gap, sometimes none, and burst length
        if (burst_left == 0 && gap_left == 0) begin
          gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 16);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          cmd_on_bus = command_queue.pop_front();
          offering   = 1'b1;
        end
      end
    end
    // hold the payload steady while valid is high
    cmd_if.valid           <= offering;
    cmd_if.kind            <= cmd_on_bus.kind;
    cmd_if.index           <= cmd_on_bus.index;
    cmd_if.data_byte       <= cmd_on_bus.data_byte;
    cmd_if.receive_length  <= cmd_on_bus.rx_len;
    cmd_if.transmit_length <= cmd_on_bus.tx_len;
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest prediction and
  // stall on a 16-bit ready mask redrawn every period.
  // --------------------------------------------------------------------------
  spi_result_t due_result;
  logic [15:0] ready_mask      = '1;
  int unsigned ready_phase     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_CAP)
        $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_phase = 0;
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (engine_results_due.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          due_result = engine_results_due.pop_front();
          results_checked++;
          check_field("out_byte", due_result.out_byte, res_if.out_byte);
          check_field("byte_valid", 8'(due_result.byte_valid), 8'(res_if.byte_valid));
          check_field("status", 8'(due_result.status), 8'(res_if.status));
          check_field("transfer_done", 8'(due_result.transfer_done),
                      8'(res_if.transfer_done));
          check_field("buffer_busy", 8'(due_result.buffer_busy), 8'(res_if.buffer_busy));
          check_field("overflow_count", due_result.overflow_count, res_if.overflow_count);
        end
      end
      // redraw: half the periods open, others random or nearly shut
      if (ready_phase == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    ready_mask = '1;
          2:       ready_mask = 16'($urandom);
          default: ready_mask = 16'h8001;
        endcase
      end
      res_if.ready <= ready_mask[ready_phase];
      ready_phase = (ready_phase + 1) % 16;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Sequence the run: plan all commands, release reset, wait for the last
  // result, settle, report.
  // --------------------------------------------------------------------------
  bit timed_out       = 1'b0;
  bit long_storm_done = 1'b0;
  int unsigned pick;

  initial begin
    // drive every input to a known level from time zero
    cmd_if.valid           = 1'b0;
    cmd_if.kind            = '0;
    cmd_if.index           = '0;
    cmd_if.data_byte       = '0;
    cmd_if.receive_length  = '0;
    cmd_if.transmit_length = '0;
    res_if.ready           = 1'b0;

    queue_opening();
    while (planned_count < COMMAND_TARGET) begin
      // one storm long enough to wrap the refusal counter
      if (!long_storm_done && planned_count > COMMAND_TARGET / 2) begin
        queue_request_storm(270);
        long_storm_done = 1'b1;
      end
      pick = $urandom_range(0, 15);
      if (pick <= 10)      queue_transaction();
      else if (pick == 11) queue_request_storm($urandom_range(10, 60));
      else if (pick == 12) queue_drain();
      else                 queue_noise();
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while ((command_queue.size() != 0 || offering || engine_results_due.size() != 0)
           && quiet_cycles < STALL_LIMIT)
      @(posedge clk);

    if (quiet_cycles >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $error("no beat moved for %0d cycles, %0d commands unsent", STALL_LIMIT,
             command_queue.size());
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (engine_results_due.size() != 0) begin
      $error("%0d predicted results never arrived", engine_results_due.size());
      mismatch_count++;
    end

    $display("Checked %0d results for %0d accepted commands (%0d mismatches).",
             results_checked, commands_accepted, mismatch_count);
    $display("Covered %0d refused requests, %0d full-FIFO drops and %0d popped bytes.",
             refusals_seen, drops_seen, pops_seen);

    if (mismatch_count == 0 && !timed_out)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule : spi_master_transaction_engine_core_test

[spi_master_transaction_engine_core.f]
src/spi_mte_pkg.sv
src/spi_mte_in_if.sv
src/spi_mte_out_if.sv
src/spi_mte_ctrl.sv
src/spi_mte_dp.sv
src/spi_master_transaction_engine_core.sv
tb/spi_master_transaction_engine_core_test.sv
